[src/sps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the stepper position sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int TICK_BITS      = 16;
  localparam int DLY_W          = TICK_BITS + 1;
  localparam int POS_W          = 6;
  localparam int QCNT_W         = 5;
  localparam int STEPS_PER_TURN = 48;

  localparam logic [TICK_BITS-1:0] CAL_INTERVAL = TICK_BITS'(100);
  localparam logic [POS_W-1:0]     LAST_POS     = POS_W'(STEPS_PER_TURN - 1);

  // request codes on the input channel
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_CAL   = 3'd1,
    OP_GOTO  = 3'd2,
    OP_WAIT  = 3'd3,
    OP_SPEED = 3'd4
  } op_t;

  // sequencer modes
  typedef enum logic [1:0] {
    MODE_CAL  = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_IDLE = 2'd2,
    MODE_WAIT = 2'd3
  } mode_t;

  // one queued command
  typedef struct packed {
    mode_t                mode;
    logic [POS_W-1:0]     pos;
    logic [TICK_BITS-1:0] wait_cnt;
    logic [TICK_BITS-1:0] step;
  } cmd_entry_t;

  // front to queue
  typedef struct packed {
    logic       push;
    cmd_entry_t entry;
  } push_req_t;

  // queue to front and back
  typedef struct packed {
    logic       empty;
    logic       full;
    cmd_entry_t head;
  } fifo_status_t;

  // one result item
  typedef struct packed {
    logic              step_right;
    logic              step_left;
    logic [POS_W-1:0]  position;
    mode_t             mode;
    logic              dropped;
    logic [QCNT_W-1:0] queued;
  } result_t;

endpackage

[src/stepper_position_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_position_sequencer_top
// Stepper motor sequencer with a command queue and tick-driven stepping.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while in_ready is high; each yields
// exactly one result, stored in the result buffer. A two-entry result buffer
// sits at the output, so in_ready only drops when two results wait to be
// taken; in_ready does not depend on out_ready in the same cycle. Commands go
// into a QUEUE_DEPTH entry queue; ticks drive the step sequencer, which pops
// that queue when idle. No clearing pass runs after reset.
module stepper_position_sequencer_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    operation,
  input  logic                          detector_active,
  input  logic [sps_pkg::POS_W-1:0]     target_position,
  input  logic [sps_pkg::TICK_BITS-1:0] wait_ticks,
  input  logic [sps_pkg::TICK_BITS-1:0] step_ticks,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          step_right,
  output logic                          step_left,
  output logic [sps_pkg::POS_W-1:0]     position,
  output logic [1:0]                    mode,
  output logic                          command_dropped,
  output logic [sps_pkg::QCNT_W-1:0]    queued_commands
);
  import sps_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             in_fire;
  logic             tick;
  logic             out_pop;
  push_req_t        push_req;
  fifo_status_t     fifo_stat;
  logic             pop;
  logic             dropped;
  logic [CNT_W-1:0] count_next;
  logic             right_s;
  logic             left_s;
  logic [POS_W-1:0] pos_next;
  mode_t            mode_s;
  result_t          res;
  result_t          slot0;
  result_t          slot1;
  logic [1:0]       occ;

  assign in_fire = in_valid && in_ready;
  assign tick    = in_fire && (op_t'(operation) == OP_TICK);
  assign out_pop = out_valid && out_ready;

  sps_front u_front (
    .fire            (in_fire),
    .operation       (operation),
    .target_position (target_position),
    .wait_ticks      (wait_ticks),
    .step_ticks      (step_ticks),
    .fifo_stat       (fifo_stat),
    .push_req        (push_req),
    .dropped         (dropped)
  );

  sps_cmd_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_req   (push_req),
    .pop        (pop),
    .fifo_stat  (fifo_stat),
    .count_next (count_next)
  );

  sps_back u_back (
    .clk             (clk),
    .rst             (rst),
    .tick            (tick),
    .detector_active (detector_active),
    .fifo_stat       (fifo_stat),
    .pop             (pop),
    .step_right      (right_s),
    .step_left       (left_s),
    .position_next   (pos_next),
    .mode_next       (mode_s)
  );

  // assemble the result of this request
  always_comb begin
    res.step_right = right_s;
    res.step_left  = left_s;
    res.position   = pos_next;
    res.mode       = mode_s;
    res.dropped    = dropped;
    res.queued     = QCNT_W'(count_next);
  end

  // result buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + {1'b0, in_fire} - {1'b0, out_pop};
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (out_pop) begin
      if (occ == 2'd2) begin
        slot0 <= slot1;
      end else if (in_fire) begin
        slot0 <= res;
      end
    end else if (in_fire) begin
      if (occ == 2'd0) begin
        slot0 <= res;
      end else begin
        slot1 <= res;
      end
    end
  end

  assign in_ready        = (occ != 2'd2);
  assign out_valid       = (occ != 2'd0);
  assign step_right      = slot0.step_right;
  assign step_left       = slot0.step_left;
  assign position        = slot0.position;
  assign mode            = slot0.mode;
  assign command_dropped = slot0.dropped;
  assign queued_commands = slot0.queued;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ != 2'd3)
    else $error("result buffer overflow");

  a_pulse_no_drop: assert property (@(posedge clk) disable iff (rst)
    in_fire && (res.step_right || res.step_left) |-> !res.dropped)
    else $error("step pulse on a dropped command");

  a_right_cal: assert property (@(posedge clk) disable iff (rst)
    in_fire && res.step_right |-> res.mode == MODE_CAL)
    else $error("step right outside calibration");

  a_stall_has_out: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

[src/sps_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_front
// Classifies accepted command requests, range checks goto targets and
// builds queue entries; reports dropped commands.
// ----------------------------------------------------------------------------
module sps_front (
  input  logic                         fire,
  input  logic [2:0]                   operation,
  input  logic [sps_pkg::POS_W-1:0]    target_position,
  input  logic [sps_pkg::TICK_BITS-1:0] wait_ticks,
  input  logic [sps_pkg::TICK_BITS-1:0] step_ticks,
  input  sps_pkg::fifo_status_t        fifo_stat,
  output sps_pkg::push_req_t           push_req,
  output logic                         dropped
);
  import sps_pkg::*;

  logic       is_cmd;
  cmd_entry_t entry;

  // decode the request into a queue entry
  always_comb begin
    is_cmd         = 1'b1;
    entry.mode     = MODE_IDLE;
    entry.pos      = '0;
    entry.wait_cnt = '0;
    entry.step     = '0;
    dropped        = 1'b0;
    case (op_t'(operation))
      OP_CAL: begin
        entry.mode = MODE_CAL;
        entry.step = CAL_INTERVAL;
      end
      OP_GOTO: begin
        entry.mode = MODE_MOVE;
        entry.pos  = target_position;
        if (target_position > LAST_POS) begin
          is_cmd  = 1'b0;
          dropped = fire;
        end
      end
      OP_WAIT: begin
        entry.mode     = MODE_WAIT;
        entry.wait_cnt = wait_ticks;
      end
      OP_SPEED: begin
        entry.mode = MODE_IDLE;
        entry.step = step_ticks;
      end
      default: is_cmd = 1'b0;
    endcase
    // full queue drops the command
    if (fire && is_cmd && fifo_stat.full) begin
      dropped = 1'b1;
    end
    push_req.push  = fire && is_cmd && !fifo_stat.full;
    push_req.entry = entry;
  end

endmodule

[src/sps_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_cmd_fifo
// Command queue between front and back; head entry is visible without a
// read request, count after the current request is reported.
// ----------------------------------------------------------------------------
module sps_cmd_fifo #(
  parameter int QUEUE_DEPTH = 16,
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sps_pkg::push_req_t    push_req,
  input  logic                  pop,
  output sps_pkg::fifo_status_t fifo_stat,
  output logic [CNT_W-1:0]      count_next
);
  import sps_pkg::*;

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_entry_t       store [QUEUE_DEPTH];
  cmd_entry_t       head_entry;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  // head pointer after this request
  always_comb begin
    head_next = head;
    if (pop) begin
      head_next = (head == LAST_PTR) ? '0 : head + 1'b1;
    end
  end

  // entry storage and registered head entry
  always_ff @(posedge clk) begin
    if (push_req.push) begin
      store[tail] <= push_req.entry;
    end
    // a write into the next head slot bypasses the storage
    if (push_req.push && (tail == head_next)) begin
      head_entry <= push_req.entry;
    end else begin
      head_entry <= store[head_next];
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push_req.push) begin
        tail <= (tail == LAST_PTR) ? '0 : tail + 1'b1;
      end
      head  <= head_next;
      count <= count_next;
    end
  end

  // status and count after this request
  always_comb begin
    fifo_stat.empty = (count == '0);
    fifo_stat.full  = (count >= FULL_CNT);
    fifo_stat.head  = head_entry;
    count_next      = count;
    if (push_req.push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push_req.push) begin
      count_next = count - 1'b1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push_req.push |-> count != FULL_CNT)
    else $error("push into full queue");

endmodule

[src/sps_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_back
// Step sequencer: on each tick request either counts down the pending
// delay or runs one step of calibration, move, command pop or wait.
// ----------------------------------------------------------------------------
module sps_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     tick,
  input  logic                     detector_active,
  input  sps_pkg::fifo_status_t    fifo_stat,
  output logic                     pop,
  output logic                     step_right,
  output logic                     step_left,
  output logic [sps_pkg::POS_W-1:0] position_next,
  output sps_pkg::mode_t           mode_next
);
  import sps_pkg::*;

  mode_t                mode;
  logic [POS_W-1:0]     cur_pos;
  logic [POS_W-1:0]     des_pos;
  logic [POS_W-1:0]     des_pos_next;
  logic [TICK_BITS-1:0] pend_wait;
  logic [TICK_BITS-1:0] pend_wait_next;
  logic [TICK_BITS-1:0] step_int;
  logic [TICK_BITS-1:0] step_int_next;
  logic [DLY_W-1:0]     delay_left;
  logic [DLY_W-1:0]     delay_left_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      cur_pos    <= '0;
      des_pos    <= '0;
      pend_wait  <= '0;
      step_int   <= CAL_INTERVAL;
      delay_left <= '0;
    end else begin
      mode       <= mode_next;
      cur_pos    <= position_next;
      des_pos    <= des_pos_next;
      pend_wait  <= pend_wait_next;
      step_int   <= step_int_next;
      delay_left <= delay_left_next;
    end
  end

  // next state and step pulses
  always_comb begin
    mode_next       = mode;
    position_next   = cur_pos;
    des_pos_next    = des_pos;
    pend_wait_next  = pend_wait;
    step_int_next   = step_int;
    delay_left_next = delay_left;
    step_right      = 1'b0;
    step_left       = 1'b0;
    pop             = 1'b0;
    if (tick) begin
      if (delay_left != '0) begin
        delay_left_next = delay_left - 1'b1;
      end else begin
        case (mode)
          MODE_CAL: begin
            if (!detector_active) begin
              step_right = 1'b1;
            end else begin
              position_next = '0;
              des_pos_next  = '0;
              mode_next     = MODE_IDLE;
            end
            delay_left_next = DLY_W'(step_int);
          end
          MODE_MOVE: begin
            if (cur_pos != des_pos) begin
              step_left     = 1'b1;
              position_next = (cur_pos == LAST_POS) ? '0 : cur_pos + 1'b1;
            end else begin
              mode_next = MODE_IDLE;
            end
            delay_left_next = DLY_W'(step_int);
          end
          MODE_IDLE: begin
            // pop next command, nothing happens on an empty queue
            if (!fifo_stat.empty) begin
              pop            = 1'b1;
              des_pos_next   = fifo_stat.head.pos;
              pend_wait_next = fifo_stat.head.wait_cnt;
              mode_next      = fifo_stat.head.mode;
              if (fifo_stat.head.step != '0) begin
                step_int_next = fifo_stat.head.step;
              end
              delay_left_next = DLY_W'(step_int_next);
            end
          end
          MODE_WAIT: begin
            mode_next       = MODE_IDLE;
            delay_left_next = DLY_W'(pend_wait) + DLY_W'(step_int);
          end
          default: mode_next = MODE_IDLE;
        endcase
      end
    end
  end

  a_one_pulse: assert property (@(posedge clk) disable iff (rst)
    !(step_right && step_left))
    else $error("both step pulses at once");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (mode == MODE_IDLE) && tick && (delay_left == '0))
    else $error("command popped outside idle step");

  a_delay_load: assert property (@(posedge clk) disable iff (rst)
    (step_right || step_left) |=> delay_left == $past(DLY_W'(step_int)))
    else $error("step without delay reload");

endmodule
